// ----- hw/rtl/modbus_rtu_crc_framer_defines.svh -----
// Assertion macros used by the framer's checker file.
`ifndef MODBUS_RTU_CRC_FRAMER_DEFINES_SVH
`define MODBUS_RTU_CRC_FRAMER_DEFINES_SVH

// Antecedent at one edge implies consequent at the next edge.
`define MRCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modbus framer check failed: next-cycle rule");

// Delayed form: antecedent at one edge implies the consequent at a later edge.
`define MRCF_ASSERT_AFTER2(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("modbus framer check failed: two-cycle rule");

`endif

// ----- hw/rtl/mrcf_pkg.sv -----
// Types and constants of the Modbus RTU CRC framer.
`default_nettype none

package mrcf_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] TABLE_POLY = 16'hA001;

    localparam int unsigned PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_USE_POLY       = 2'd1,
        REG_POLY           = 2'd2,
        REG_HIGH_FIRST     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_beat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mrcf_crc_fold.sv -----
// Folds one byte into a reflected, LSB-first CRC-16.
`default_nettype none

module mrcf_crc_fold (
    input  wire logic [15:0] crc,
    input  wire logic [7:0]  data,
    input  wire logic [15:0] poly,
    output logic      [15:0] crc_out
);
    import mrcf_pkg::*;

    logic [15:0] c;

    always_comb
    begin
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ poly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/modbus_rtu_crc_framer.sv -----
// Modbus RTU request framer: address insertion, CRC-16 and trailer bytes.
`default_nettype none

// Request bytes enter from the function code onward, one beat per byte, with
// end_of_frame on the last one. The block emits one frame byte per cycle
// while frame_ready does not stall it, through a single output register: a
// middle byte yields its data byte, the first byte of a frame the address and
// then the data, the last byte the data and two CRC bytes, a one-byte frame
// all four. That rate is set by the output register; the 8-bit CRC fold for
// each address and data byte is combinational. A taken request byte waits in
// the hold register, then its first frame byte enters the output register.
// Configure only while idle; use_poly chooses the polynomial
// register or the fixed Modbus one, and high_first sets the CRC byte order
// (in table mode high_first=1 gives the standard low-byte-first order).

module modbus_rtu_crc_framer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          byte_valid,
    output logic                               byte_ready,
    input  wire mrcf_pkg::in_beat_t            byte_data,
    output logic                               frame_valid,
    input  wire logic                          frame_ready,
    output mrcf_pkg::out_beat_t                frame_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mrcf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import mrcf_pkg::*;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_DATA,
        PH_CRC1,
        PH_CRC2
    } phase_t;

    // Configuration
    logic [7:0]  dev_addr_reg;
    logic        use_poly_reg;
    logic [15:0] poly_reg;
    logic        high_first_reg;

    // Pipeline
    logic        hold_valid_reg, hold_valid_next;
    in_beat_t    hold_reg;
    phase_t      phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_reg;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] crc_reg, crc_next;

    logic        cfg_write;
    reg_idx_t    cfg_idx;
    logic        advance;
    logic        load;
    logic        item_done;
    logic        low_first;
    phase_t      beat_phase;
    out_beat_t   beat;
    logic [7:0]  fold_data;
    logic [15:0] fold_poly;
    logic [15:0] fold_crc;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_DEVICE_ADDRESS: prdata = {24'd0, dev_addr_reg};
            REG_USE_POLY:       prdata = {31'd0, use_poly_reg};
            REG_POLY:           prdata = {16'd0, poly_reg};
            REG_HIGH_FIRST:     prdata = {31'd0, high_first_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign advance   = hold_valid_reg & (~out_valid_reg | frame_ready);
    assign fold_poly = use_poly_reg ? poly_reg : TABLE_POLY;
    assign low_first = use_poly_reg ? ~high_first_reg : high_first_reg;

    mrcf_crc_fold u_fold (
        .crc     (crc_reg),
        .data    (fold_data),
        .poly    (fold_poly),
        .crc_out (fold_crc)
    );

    // Byte emitted by the held item in its current phase.
    always_comb
    begin
        fold_data  = hold_reg.data_byte;
        beat       = '{out_byte: hold_reg.data_byte, out_last: 1'b0};
        item_done  = 1'b0;
        beat_phase = phase_reg;
        unique case (phase_reg)
            PH_ADDR:
            begin
                fold_data  = dev_addr_reg;
                beat       = '{out_byte: dev_addr_reg, out_last: 1'b0};
                beat_phase = PH_DATA;
            end
            PH_DATA:
            begin
                item_done  = ~hold_reg.end_of_frame;
                beat_phase = PH_CRC1;
            end
            PH_CRC1:
            begin
                beat.out_byte = low_first ? crc_reg[7:0] : crc_reg[15:8];
                beat_phase    = PH_CRC2;
            end
            PH_CRC2:
            begin
                beat.out_byte = low_first ? crc_reg[15:8] : crc_reg[7:0];
                beat.out_last = 1'b1;
                item_done     = 1'b1;
                beat_phase    = PH_ADDR;
            end
            default:
            begin
                beat_phase = PH_ADDR;
            end
        endcase
    end

    assign byte_ready = ~hold_valid_reg | (advance & item_done);
    assign load       = byte_valid & byte_ready;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        if (advance)
        begin
            if (phase_reg == PH_ADDR || phase_reg == PH_DATA)
            begin
                crc_next = fold_crc;
            end
            if (phase_reg == PH_ADDR)
            begin
                in_frame_next = 1'b1;
            end
            else if (phase_reg == PH_CRC2)
            begin
                in_frame_next = 1'b0;
                crc_next      = CRC_INIT;
            end
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        if (advance)
        begin
            phase_next = beat_phase;
            if (item_done)
            begin
                hold_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            hold_valid_next = 1'b1;
            phase_next      = in_frame_next ? PH_DATA : PH_ADDR;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= 8'd1;
            use_poly_reg   <= 1'b0;
            poly_reg       <= TABLE_POLY;
            high_first_reg <= 1'b1;
            hold_valid_reg <= 1'b0;
            phase_reg      <= PH_ADDR;
            out_valid_reg  <= 1'b0;
            in_frame_reg   <= 1'b0;
            crc_reg        <= CRC_INIT;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx)
                    REG_DEVICE_ADDRESS: dev_addr_reg   <= pwdata[7:0];
                    REG_USE_POLY:       use_poly_reg   <= pwdata[0];
                    REG_POLY:           poly_reg       <= pwdata[15:0];
                    REG_HIGH_FIRST:     high_first_reg <= pwdata[0];
                    default:            dev_addr_reg   <= dev_addr_reg;
                endcase
            end
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            in_frame_reg   <= in_frame_next;
            crc_reg        <= crc_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= byte_data;
        end
        if (advance)
        begin
            out_reg <= beat;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mrcf_checker.sv -----
// Port-level checks for the Modbus RTU framer, bound to the top level.
`default_nettype none

`include "modbus_rtu_crc_framer_defines.svh"

module mrcf_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                byte_valid,
    input wire logic                byte_ready,
    input wire logic                frame_valid,
    input wire logic                frame_ready,
    input wire mrcf_pkg::out_beat_t frame_data
);
    import mrcf_pkg::*;

    // A stalled output beat stays put.
    `MRCF_ASSERT_NEXT(a_out_hold, frame_valid && !frame_ready, frame_valid && $stable(frame_data))

    // Every taken byte must be followed by a valid output beat at a later edge.
    `MRCF_ASSERT_AFTER2(a_in_to_out, byte_valid && byte_ready, frame_valid)

    // A full block opens to input only when the output moves.
    `MRCF_ASSERT_NEXT(a_stall_closed, !frame_ready && !byte_ready, !byte_ready || frame_ready)

endmodule

bind modbus_rtu_crc_framer mrcf_checker u_mrcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_data  (frame_data)
);

`default_nettype wire
